// ----- rtl/pfc_pkg.sv -----
// Package for the presence fan controller: field widths, register indexes,
// reset values, command characters, event codes and shared state structs.
// Used by every other file of the block; depends on nothing.
package pfc_pkg;

    localparam int ECHO_W     = 16;
    localparam int DIST_W     = 9;
    localparam int CMD_W      = 8;
    localparam int CNT_W      = 16;
    localparam int RUN_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ON_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_FLOOR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRACE        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_IVL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STATUS_IVL   = 3'd5;

    localparam logic [CFG_DATA_W-1:0] RST_ON_THRESHOLD = 16'd4081;
    localparam logic [CFG_DATA_W-1:0] RST_NEAR_FLOOR   = 16'd200;
    localparam logic [CFG_DATA_W-1:0] RST_GRACE        = 16'd300;
    localparam logic [CFG_DATA_W-1:0] RST_TIMEOUT      = 16'd60000;
    localparam logic [CFG_DATA_W-1:0] RST_MEASURE_IVL  = 16'd400;
    localparam logic [CFG_DATA_W-1:0] RST_STATUS_IVL   = 16'd200;

    localparam logic OP_COMMAND = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam logic [CMD_W-1:0] CMD_AWAKE   = 8'h41; // 'A'
    localparam logic [CMD_W-1:0] CMD_HUMAN   = 8'h48; // 'H'
    localparam logic [CMD_W-1:0] CMD_DEPART  = 8'h44; // 'D'
    localparam logic [CMD_W-1:0] CMD_LEFT    = 8'h4C; // 'L'
    localparam logic [CMD_W-1:0] CMD_MANUAL  = 8'h4D; // 'M'
    localparam logic [CMD_W-1:0] CMD_AUTO    = 8'h4F; // 'O'
    localparam logic [CMD_W-1:0] CMD_FAN     = 8'h46; // 'F'
    localparam logic [CMD_W-1:0] CMD_ONE     = 8'h31; // '1'
    localparam logic [CMD_W-1:0] CMD_ZERO    = 8'h30; // '0'

    // echoes of zero or at/above this limit are held but give no distance
    localparam logic [ECHO_W-1:0] ECHO_VALID_LIMIT = 16'd25000;
    // floor(e / 58) == (e * 18079) >> 20 for every e below the valid limit
    localparam int               RECIP_SHIFT = 20;
    localparam logic [14:0]      RECIP_58    = 15'd18079;
    localparam int               PROD_W      = ECHO_W + 15;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_MANUAL  = 3'd1,
        EV_AUTO    = 3'd2,
        EV_FAN_ON  = 3'd3,
        EV_FAN_OFF = 3'd4,
        EV_TIMEOUT = 3'd5
    } event_t;

    typedef struct packed {
        logic             fan_on;
        logic [CNT_W-1:0] grace_count;
        logic [RUN_W-1:0] run_ticks;
    } fan_state_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] on_threshold_us;
        logic [CFG_DATA_W-1:0] near_floor_us;
        logic [CFG_DATA_W-1:0] grace_ticks;
        logic [CFG_DATA_W-1:0] timeout_ticks;
    } auto_cfg_t;

endpackage

// ----- rtl/pfc_in_if.sv -----
// Input channel of the presence fan controller: valid/ready plus one request.
// Depends on pfc_pkg for field widths.
interface pfc_in_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [pfc_pkg::CMD_W-1:0]    command_byte;
    logic [pfc_pkg::ECHO_W-1:0]   echo_time_us;

    modport source (output valid, opcode, command_byte, echo_time_us, input ready);
    modport sink   (input valid, opcode, command_byte, echo_time_us, output ready);
endinterface

// ----- rtl/pfc_out_if.sv -----
// Result channel of the presence fan controller: valid/ready plus one result.
// Depends on pfc_pkg for field widths.
interface pfc_out_if;
    logic                         valid;
    logic                         ready;
    logic                         fan_running;
    logic                         manual_mode;
    logic [2:0]                   event_res;
    logic                         status_due;
    logic [pfc_pkg::ECHO_W-1:0]   reported_time_us;
    logic [pfc_pkg::DIST_W-1:0]   range_cm;

    modport source (output valid, fan_running, manual_mode, event_res, status_due,
                    reported_time_us, range_cm, input ready);
    modport sink   (input valid, fan_running, manual_mode, event_res, status_due,
                    reported_time_us, range_cm, output ready);
endinterface

// ----- rtl/presence_fan_controller.sv -----
// Presence fan controller, top level.
// Depends on pfc_pkg, pfc_in_if, pfc_out_if and pfc_auto.
//
// Usage:
//   in_ch carries one request per handshake: a command byte (opcode 0) or a
//   loop tick (opcode 1) with the latest echo time. Every request yields
//   exactly one result on out_ch: fan state, mode, event code, status flag,
//   held echo time and last valid distance in cm.
//   Configuration: six 16-bit registers written through cfg_we/cfg_index/
//   cfg_data, one per cycle; the user must write them only while no request
//   is in flight; the block does not enforce it. The result is registered:
//   it shows in the cycle after acceptance; one request per cycle unless
//   out_ch stalls. All work is one pass of logic between the accepted request
//   and the result register; the distance uses one 16x15 reciprocal multiply.
//   Stall: in_ch.ready stays high while the result register is empty or is
//   being taken in the same cycle; a stalled result holds, and new requests
//   wait.
//   Reset: rst_n clears all state to zero, loads the register defaults and
//   empties the result register; no clearing pass is needed.
module presence_fan_controller (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pfc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pfc_pkg::CFG_DATA_W-1:0]    cfg_data,
    pfc_in_if.sink                            in_ch,
    pfc_out_if.source                         out_ch
);
    import pfc_pkg::*;

    // configuration
    logic [CFG_DATA_W-1:0] on_threshold_reg, near_floor_reg, grace_reg;
    logic [CFG_DATA_W-1:0] timeout_reg, measure_ivl_reg, status_ivl_reg;

    // block state
    logic              manual_reg, manual_next;
    logic              person_reg, person_next;
    logic              prefix_reg, prefix_next;
    fan_state_t        fan_reg, fan_next;
    logic [ECHO_W-1:0] held_echo_reg, held_echo_next;
    logic [DIST_W-1:0] held_dist_reg, held_dist_next;
    logic [CNT_W-1:0]  sample_reg, sample_next;
    logic [CNT_W-1:0]  report_reg, report_next;

    // result register
    logic              out_valid_reg;
    logic              out_fan_reg, out_manual_reg, out_status_reg;
    event_t            out_event_reg;
    logic [ECHO_W-1:0] out_echo_reg;
    logic [DIST_W-1:0] out_dist_reg;

    logic              in_acc;
    event_t            ev;
    logic              status;

    logic [CNT_W-1:0]  sample_inc, report_inc;
    logic              sample_hit, report_hit, echo_valid;
    logic [ECHO_W-1:0] tick_echo;
    logic [PROD_W-1:0] dist_prod;
    logic [DIST_W-1:0] dist_q;
    auto_cfg_t         auto_cfg;
    fan_state_t        auto_fan;
    logic              auto_timeout;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_acc      = in_ch.valid && in_ch.ready;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_threshold_reg <= RST_ON_THRESHOLD;
            near_floor_reg   <= RST_NEAR_FLOOR;
            grace_reg        <= RST_GRACE;
            timeout_reg      <= RST_TIMEOUT;
            measure_ivl_reg  <= RST_MEASURE_IVL;
            status_ivl_reg   <= RST_STATUS_IVL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ON_THRESHOLD: on_threshold_reg <= cfg_data;
                CFG_NEAR_FLOOR:   near_floor_reg   <= cfg_data;
                CFG_GRACE:        grace_reg        <= cfg_data;
                CFG_TIMEOUT:      timeout_reg      <= cfg_data;
                CFG_MEASURE_IVL:  measure_ivl_reg  <= cfg_data;
                CFG_STATUS_IVL:   status_ivl_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------ tick path
    assign sample_inc = sample_reg + 1'b1;
    assign report_inc = report_reg + 1'b1;
    assign sample_hit = (sample_inc >= measure_ivl_reg);
    assign report_hit = (report_inc >= status_ivl_reg);
    assign tick_echo  = sample_hit ? in_ch.echo_time_us : held_echo_reg;

    assign echo_valid = (in_ch.echo_time_us != '0) && (in_ch.echo_time_us < ECHO_VALID_LIMIT);
    assign dist_prod  = PROD_W'(in_ch.echo_time_us) * PROD_W'(RECIP_58);
    assign dist_q     = dist_prod[RECIP_SHIFT +: DIST_W];

    assign auto_cfg.on_threshold_us = on_threshold_reg;
    assign auto_cfg.near_floor_us   = near_floor_reg;
    assign auto_cfg.grace_ticks     = grace_reg;
    assign auto_cfg.timeout_ticks   = timeout_reg;

    pfc_auto u_auto (
        .echo_us     (tick_echo),
        .person_seen (person_reg),
        .cfg         (auto_cfg),
        .cur         (fan_reg),
        .nxt         (auto_fan),
        .timeout     (auto_timeout)
    );

    // ------------------------------------------------------- next state
    always_comb
    begin
        manual_next    = manual_reg;
        person_next    = person_reg;
        prefix_next    = prefix_reg;
        fan_next       = fan_reg;
        held_echo_next = held_echo_reg;
        held_dist_next = held_dist_reg;
        sample_next    = sample_reg;
        report_next    = report_reg;
        ev             = EV_NONE;
        status         = 1'b0;

        if (in_ch.opcode == OP_COMMAND)
        begin
            case (in_ch.command_byte)
                CMD_AWAKE, CMD_HUMAN:
                    person_next = 1'b1;
                CMD_DEPART, CMD_LEFT:
                    person_next = 1'b0;
                CMD_MANUAL:
                begin
                    manual_next = 1'b1;
                    person_next = 1'b0;
                    ev          = EV_MANUAL;
                end
                CMD_AUTO:
                begin
                    manual_next = 1'b0;
                    ev          = EV_AUTO;
                end
                CMD_FAN:
                    prefix_next = 1'b1;
                CMD_ONE:
                begin
                    if (prefix_reg)
                    begin
                        prefix_next = 1'b0;
                        if (manual_reg)
                        begin
                            fan_next.fan_on    = 1'b1;
                            fan_next.run_ticks = '0;
                            ev                 = EV_FAN_ON;
                        end
                    end
                    else
                    begin
                        person_next = 1'b1;
                    end
                end
                CMD_ZERO:
                begin
                    if (prefix_reg)
                    begin
                        prefix_next = 1'b0;
                        if (manual_reg)
                        begin
                            fan_next.fan_on = 1'b0;
                            ev              = EV_FAN_OFF;
                        end
                    end
                    else
                    begin
                        person_next = 1'b0;
                    end
                end
                default:
                    prefix_next = 1'b0;
            endcase
        end
        else
        begin
            if (sample_hit)
            begin
                sample_next    = '0;
                held_echo_next = in_ch.echo_time_us;
                if (echo_valid)
                    held_dist_next = dist_q;
            end
            else
            begin
                sample_next = sample_inc;
            end

            if (!manual_reg)
            begin
                fan_next = auto_fan;
                if (auto_timeout)
                    ev = EV_TIMEOUT;
            end

            if (report_hit)
            begin
                report_next = '0;
                status      = 1'b1;
            end
            else
            begin
                report_next = report_inc;
            end
        end
    end

    // ------------------------------------------------------- state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            manual_reg    <= 1'b0;
            person_reg    <= 1'b0;
            prefix_reg    <= 1'b0;
            fan_reg       <= '0;
            held_echo_reg <= '0;
            held_dist_reg <= '0;
            sample_reg    <= '0;
            report_reg    <= '0;
        end
        else if (in_acc)
        begin
            manual_reg    <= manual_next;
            person_reg    <= person_next;
            prefix_reg    <= prefix_next;
            fan_reg       <= fan_next;
            held_echo_reg <= held_echo_next;
            held_dist_reg <= held_dist_next;
            sample_reg    <= sample_next;
            report_reg    <= report_next;
        end
    end

    // ------------------------------------------------------ result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_acc)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            out_fan_reg    <= fan_next.fan_on;
            out_manual_reg <= manual_next;
            out_event_reg  <= ev;
            out_status_reg <= status;
            out_echo_reg   <= held_echo_next;
            out_dist_reg   <= held_dist_next;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.fan_running      = out_fan_reg;
    assign out_ch.manual_mode      = out_manual_reg;
    assign out_ch.event_res        = out_event_reg;
    assign out_ch.status_due       = out_status_reg;
    assign out_ch.reported_time_us = out_echo_reg;
    assign out_ch.range_cm         = out_dist_reg;

`ifndef NO_ASSERTIONS
    a_cmd_no_status: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_ch.opcode == OP_COMMAND |=> !out_status_reg)
        else $error("status flagged on a command request");

    a_timeout_stops_fan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_event_reg == EV_TIMEOUT |-> !out_fan_reg && !out_manual_reg)
        else $error("timeout event with fan running or in manual mode");

    a_fan_on_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_event_reg == EV_FAN_ON |-> out_fan_reg && out_manual_reg)
        else $error("fan-on event without manual fan running");

    a_empty_takes_request: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ch.ready)
        else $error("request refused while result register is empty");
`endif

endmodule

// ----- rtl/pfc_auto.sv -----
// Auto-mode fan decision for one tick: range check, grace count, run timeout.
// Purely combinational; depends on pfc_pkg for the state and config structs.
module pfc_auto (
    input  logic [pfc_pkg::ECHO_W-1:0] echo_us,
    input  logic                       person_seen,
    input  pfc_pkg::auto_cfg_t         cfg,
    input  pfc_pkg::fan_state_t        cur,
    output pfc_pkg::fan_state_t        nxt,
    output logic                       timeout
);
    import pfc_pkg::*;

    logic             close_enough;
    logic [CNT_W-1:0] grace_inc;
    logic [RUN_W-1:0] run_inc;
    fan_state_t       mid;

    assign grace_inc = cur.grace_count + 1'b1;

    always_comb
    begin
        // too close or no echo: trust the camera alone
        if (echo_us == '0 || echo_us < cfg.near_floor_us)
            close_enough = person_seen;
        else
            close_enough = (echo_us <= cfg.on_threshold_us);

        mid = cur;
        if (person_seen && close_enough)
        begin
            mid.grace_count = '0;
            if (!cur.fan_on)
            begin
                mid.fan_on    = 1'b1;
                mid.run_ticks = '0;
            end
        end
        else if (cur.fan_on)
        begin
            if (!person_seen || grace_inc >= cfg.grace_ticks)
            begin
                mid.fan_on      = 1'b0;
                mid.grace_count = '0;
                mid.run_ticks   = '0;
            end
            else
            begin
                mid.grace_count = grace_inc;
            end
        end
    end

    assign run_inc = mid.run_ticks + 1'b1;

    always_comb
    begin
        nxt     = mid;
        timeout = 1'b0;
        if (mid.fan_on)
        begin
            if (run_inc > RUN_W'(cfg.timeout_ticks))
            begin
                nxt.fan_on      = 1'b0;
                nxt.run_ticks   = '0;
                nxt.grace_count = '0;
                timeout         = 1'b1;
            end
            else
            begin
                nxt.run_ticks = run_inc;
            end
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for presence_fan_controller: streams command bytes and
// loop ticks, predicts each result in-line and checks every result as it leaves.
// Depends on pfc_pkg, pfc_in_if, pfc_out_if and the presence_fan_controller RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pfc_pkg::*;

    localparam int LIMIT_CYCLES = 100000;
    localparam int HOLD_AT      = 470;
    localparam int HOLD_LEN     = 150;
    localparam int US_PER_CM    = 58;
    localparam int MAX_PRINTED  = 50;

    typedef struct packed {
        logic              opcode;
        logic [CMD_W-1:0]  cmd;
        logic [ECHO_W-1:0] echo;
    } fan_request_t;

    typedef struct packed {
        logic              fan;
        logic              manual;
        event_t            ev;
        logic              status;
        logic [ECHO_W-1:0] echo;
        logic [DIST_W-1:0] dist_cm;
    } fan_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic src_valid = 1'b0;
    fan_request_t cur_request = '0;
    logic rcv_ready = 1'b0;
    logic steady = 1'b0;

    fan_request_t pending_requests[$];
    fan_result_t predicted_results[$];
    fan_result_t want;
    int requests_issued = 0;
    int requests_taken = 0;
    int results_seen = 0;
    int error_count = 0;
    int cycle_count = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;

    // predictor copy of the registers and the controller state
    logic [CFG_DATA_W-1:0] cfg_on_thr = RST_ON_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_near_floor = RST_NEAR_FLOOR;
    logic [CFG_DATA_W-1:0] cfg_grace = RST_GRACE;
    logic [CFG_DATA_W-1:0] cfg_timeout = RST_TIMEOUT;
    logic [CFG_DATA_W-1:0] cfg_measure = RST_MEASURE_IVL;
    logic [CFG_DATA_W-1:0] cfg_status = RST_STATUS_IVL;
    logic st_manual = 1'b0;
    logic st_fan = 1'b0;
    logic st_person = 1'b0;
    logic st_prefix = 1'b0;
    logic [ECHO_W-1:0] st_echo = '0;
    logic [DIST_W-1:0] st_dist = '0;
    logic [RUN_W-1:0] st_run = '0;
    logic [CNT_W-1:0] st_grace = '0;
    logic [CNT_W-1:0] st_sample = '0;
    logic [CNT_W-1:0] st_report = '0;

    pfc_in_if in_ch();
    pfc_out_if out_ch();

    assign in_ch.valid = src_valid;
    assign in_ch.opcode = cur_request.opcode;
    assign in_ch.command_byte = cur_request.cmd;
    assign in_ch.echo_time_us = cur_request.echo;
    assign out_ch.ready = rcv_ready;

    presence_fan_controller DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic fan_result_t advance_controller(input fan_request_t rq);
        fan_result_t r;
        event_t ev;
        logic status;
        logic close_enough;
        ev = EV_NONE;
        status = 1'b0;
        if (rq.opcode == OP_COMMAND)
        begin
            case (rq.cmd)
                CMD_AWAKE, CMD_HUMAN: st_person = 1'b1;
                CMD_DEPART, CMD_LEFT: st_person = 1'b0;
                CMD_MANUAL:
                begin
                    st_manual = 1'b1;
                    st_person = 1'b0;
                    ev = EV_MANUAL;
                end
                CMD_AUTO:
                begin
                    st_manual = 1'b0;
                    ev = EV_AUTO;
                end
                CMD_FAN: st_prefix = 1'b1;
                CMD_ONE:
                begin
                    if (st_prefix)
                    begin
                        if (st_manual)
                        begin
                            st_fan = 1'b1;
                            st_run = '0;
                            ev = EV_FAN_ON;
                        end
                        st_prefix = 1'b0;
                    end
                    else
                        st_person = 1'b1;
                end
                CMD_ZERO:
                begin
                    if (st_prefix)
                    begin
                        if (st_manual)
                        begin
                            st_fan = 1'b0;
                            ev = EV_FAN_OFF;
                        end
                        st_prefix = 1'b0;
                    end
                    else
                        st_person = 1'b0;
                end
                default: st_prefix = 1'b0;
            endcase
        end
        else
        begin
            st_sample = st_sample + 1'b1;
            if (st_sample >= cfg_measure)
            begin
                st_sample = '0;
                st_echo = rq.echo;
                // out-of-window echoes are held for reporting but give no distance
                if (rq.echo != '0 && rq.echo < ECHO_VALID_LIMIT)
                    st_dist = DIST_W'(int'(rq.echo) / US_PER_CM);
            end
            if (!st_manual)
            begin
                if (st_echo == '0 || st_echo < cfg_near_floor)
                    close_enough = st_person;
                else
                    close_enough = (st_echo <= cfg_on_thr);
                if (st_person && close_enough)
                begin
                    st_grace = '0;
                    if (!st_fan)
                    begin
                        st_fan = 1'b1;
                        st_run = '0;
                    end
                end
                else if (st_fan)
                begin
                    if (!st_person)
                    begin
                        st_fan = 1'b0;
                        st_grace = '0;
                        st_run = '0;
                    end
                    else
                    begin
                        st_grace = st_grace + 1'b1;
                        if (st_grace >= cfg_grace)
                        begin
                            st_fan = 1'b0;
                            st_grace = '0;
                            st_run = '0;
                        end
                    end
                end
                if (st_fan)
                begin
                    st_run = st_run + 1'b1;
                    if (st_run > cfg_timeout)
                    begin
                        st_fan = 1'b0;
                        st_run = '0;
                        st_grace = '0;
                        ev = EV_TIMEOUT;
                    end
                end
            end
            st_report = st_report + 1'b1;
            if (st_report >= cfg_status)
            begin
                st_report = '0;
                status = 1'b1;
            end
        end
        r.fan = st_fan;
        r.manual = st_manual;
        r.ev = ev;
        r.status = status;
        r.echo = st_echo;
        r.dist_cm = st_dist;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        if (error_count < MAX_PRINTED)
            $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, exp_val, $realtime);
        error_count++;
    endtask

    function automatic void add_cmd(input logic [CMD_W-1:0] c);
        fan_request_t rq;
        rq.opcode = OP_COMMAND;
        rq.cmd = c;
        rq.echo = ECHO_W'($urandom);
        pending_requests.push_back(rq);
        requests_issued++;
    endfunction

    function automatic void add_tick(input logic [ECHO_W-1:0] e);
        fan_request_t rq;
        rq.opcode = OP_TICK;
        rq.cmd = CMD_W'($urandom);
        rq.echo = e;
        pending_requests.push_back(rq);
        requests_issued++;
    endfunction

    // random echoes, many clustered around the thresholds and the valid-window edges
    function automatic logic [ECHO_W-1:0] pick_echo();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 20)
            return ECHO_W'($urandom);
        else if (sel < 55)
            return ECHO_W'($urandom_range(100, 6000));
        else if (sel < 63)
            return '0;
        else if (sel < 73)
            return ECHO_W'(int'(ECHO_VALID_LIMIT) - 8 + int'($urandom_range(0, 16)));
        else if (sel < 87)
            return ECHO_W'(int'(cfg_on_thr) - 3 + int'($urandom_range(0, 6)));
        else
            return ECHO_W'(int'(cfg_near_floor) - 3 + int'($urandom_range(0, 6)));
    endfunction

    task automatic add_random(input int count);
        int kind;
        logic [CMD_W-1:0] menu [9];
        menu = '{CMD_AWAKE, CMD_HUMAN, CMD_DEPART, CMD_LEFT, CMD_MANUAL,
                 CMD_AUTO, CMD_FAN, CMD_ONE, CMD_ZERO};
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 55)
                add_tick(pick_echo());
            else if (kind < 70)
            begin
                add_cmd(CMD_FAN);
                add_cmd($urandom_range(0, 1) ? CMD_ONE : CMD_ZERO);
            end
            else if (kind < 92)
                add_cmd(menu[$urandom_range(0, 8)]);
            else
                add_cmd(CMD_W'($urandom));
        end
    endtask

    task automatic load_registers(input logic [CFG_DATA_W-1:0] thr, near, grace, tmo,
                                  meas, stat);
        logic [CFG_IDX_W-1:0] idx [6];
        logic [CFG_DATA_W-1:0] vals [6];
        idx = '{CFG_ON_THRESHOLD, CFG_NEAR_FLOOR, CFG_GRACE, CFG_TIMEOUT,
                CFG_MEASURE_IVL, CFG_STATUS_IVL};
        vals = '{thr, near, grace, tmo, meas, stat};
        for (int i = 0; i < 6; i++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_on_thr = thr;
        cfg_near_floor = near;
        cfg_grace = grace;
        cfg_timeout = tmo;
        cfg_measure = meas;
        cfg_status = stat;
    endtask

    // every request gives one result, so idle means all results are back
    task automatic wait_drained();
        while (results_seen < requests_issued)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // driver: offer queued requests, idling at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_valid <= 1'b0;
        end
        else
        begin
            if (src_valid && in_ch.ready)
            begin
                predicted_results.push_back(advance_controller(cur_request));
                requests_taken <= requests_taken + 1;
            end
            if (!src_valid || in_ch.ready)
            begin
                if (pending_requests.size() != 0 && (steady || $urandom_range(0, 99) >= 33))
                begin
                    cur_request <= pending_requests.pop_front();
                    src_valid <= 1'b1;
                end
                else
                    src_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off to back up the input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcv_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            rcv_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && requests_taken >= HOLD_AT)
        begin
            rcv_ready <= 1'b0;
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else
            rcv_ready <= steady || ($urandom_range(0, 99) >= 33);
    end

    // monitor: check each result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && rcv_ready)
        begin
            results_seen++;
            if (predicted_results.size() == 0)
                report_mismatch("result with nothing predicted", 0, 0);
            else
            begin
                want = predicted_results.pop_front();
                if (out_ch.fan_running !== want.fan)
                    report_mismatch("fan_running", out_ch.fan_running, want.fan);
                if (out_ch.manual_mode !== want.manual)
                    report_mismatch("manual_mode", out_ch.manual_mode, want.manual);
                if (out_ch.event_res !== want.ev)
                    report_mismatch("event_res", out_ch.event_res, want.ev);
                if (out_ch.status_due !== want.status)
                    report_mismatch("status_due", out_ch.status_due, want.status);
                if (out_ch.reported_time_us !== want.echo)
                    report_mismatch("reported_time_us", out_ch.reported_time_us, want.echo);
                if (out_ch.range_cm !== want.dist_cm)
                    report_mismatch("range_cm", out_ch.range_cm, want.dist_cm);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: range edges, invalid echoes, grace, timeout, every command
        load_registers(16'd4081, 16'd200, 16'd2, 16'd3, 16'd1, 16'd3);
        add_cmd(CMD_AWAKE);
        add_tick(16'd1000);
        add_tick(16'd0);
        add_tick(16'd25000);
        add_tick(16'hFFFF);
        add_tick(16'd24999);
        add_tick(16'd100);
        add_tick(16'd4081);
        add_tick(16'd4082);
        add_tick(16'd4081);
        add_cmd(CMD_LEFT);
        add_cmd(CMD_HUMAN);
        add_cmd(CMD_DEPART);
        add_cmd(CMD_ONE);
        add_cmd(CMD_ZERO);
        add_cmd(CMD_MANUAL);
        add_cmd(CMD_FAN);
        add_cmd(CMD_ONE);
        add_cmd(CMD_FAN);
        add_cmd(CMD_ONE);
        add_cmd(CMD_FAN);
        add_cmd(CMD_ZERO);
        add_cmd(CMD_FAN);
        add_cmd(8'hFF);
        add_cmd(CMD_ONE);
        add_cmd(CMD_AUTO);
        add_cmd(CMD_FAN);
        add_cmd(CMD_ONE);
        wait_drained();

        load_registers(16'd4081, 16'd200, 16'd3, 16'd40, 16'd2, 16'd5);
        add_random(80);
        wait_drained();

        load_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_random(50);
        wait_drained();

        // zero grace and zero intervals fire on every tick
        load_registers(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        add_random(50);
        wait_drained();

        load_registers(16'd1500, 16'd500, 16'd1, 16'd10, 16'd1, 16'd1);
        add_random(80);
        wait_drained();

        load_registers(16'd3000, 16'd100, 16'd5, 16'd200, 16'd3, 16'd7);
        @(posedge clk);
        steady <= 1'b1;
        add_random(110);
        wait_drained();
        steady <= 1'b0;

        load_registers(RST_ON_THRESHOLD, RST_NEAR_FLOOR, RST_GRACE, RST_TIMEOUT,
                       RST_MEASURE_IVL, RST_STATUS_IVL);
        add_random(85);
        wait_drained();

        if (predicted_results.size() != 0)
            report_mismatch("predictions left over", 0, predicted_results.size());
        if (error_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
